>>> rtl/core/assert_macros.svh
// Assertion macros shared by the day-interval RTL.
// Depends on nothing; included by modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, muted while reset is high.
`define DID_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("day interval check failed");

// Clocked check that also holds during reset.
`define DID_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("day interval check failed");

`endif

>>> rtl/core/did_pkg.sv
// Shared constants, tables and controller/datapath interface types for the
// day-interval block. No dependencies.
`default_nettype none

package did_pkg;

   localparam int YEAR_W  = 14;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int COUNT_W = 22;
   localparam int DN_W    = 23;   // serial day number, fits 16383 * 365 + extras
   localparam int REST_W  = 14;   // leap corrections plus day of year
   localparam int CHK_W   = YEAR_W + 1;
   localparam int OFS_W   = 9;

   localparam int MAX_YEAR      = 9999;
   localparam int DAYS_PER_YEAR = 365;
   localparam int MONTHS_END    = 13;
   localparam int FEB_SHORT     = 28;
   localparam int FEB_LONG      = 29;
   localparam int MONTH_FEB     = 2;
   localparam int CENTURY       = 100;
   localparam int QUAD_CENTURY  = 400;
   localparam int COUNT_MAX     = 4194303;

   // x / 100 as (x * 5243) >> 19, exact for x below 43690
   localparam int RECIP_W     = 13;
   localparam int RECIP_100   = 5243;
   localparam int RECIP_SHIFT = 19;
   localparam int MUL_W       = YEAR_W + RECIP_W;
   localparam int QUO_W       = MUL_W - RECIP_SHIFT;

   typedef struct packed {
      logic load;       // capture a new request
      logic sel;        // 0: first date, 1: second date
      logic step_div;   // quotients of the year
      logic step_chk;   // validity, quotients of the shifted year
      logic step_mul;   // year times 365, corrections
      logic step_sum;   // close out one day number
      logic finish;     // difference into the response register
   } cmd_type;

   typedef struct packed {
      logic out_busy;   // response register full and not draining
   } status_type;

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
      logic [DAY_W-1:0] len;
      case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_W'(31);
         4'd4, 4'd6, 4'd9, 4'd11:                    len = DAY_W'(30);
         4'd2:    len = leap ? DAY_W'(FEB_LONG) : DAY_W'(FEB_SHORT);
         default: len = '0;
      endcase
      return len;
   endfunction

   // days from March 1 to the first of month m, year taken to start in March
   function automatic logic [OFS_W-1:0] march_offset(input logic [MONTH_W-1:0] m);
      logic [OFS_W-1:0] ofs;
      case (m)
         4'd3:    ofs = OFS_W'(0);
         4'd4:    ofs = OFS_W'(31);
         4'd5:    ofs = OFS_W'(61);
         4'd6:    ofs = OFS_W'(92);
         4'd7:    ofs = OFS_W'(122);
         4'd8:    ofs = OFS_W'(153);
         4'd9:    ofs = OFS_W'(184);
         4'd10:   ofs = OFS_W'(214);
         4'd11:   ofs = OFS_W'(245);
         4'd12:   ofs = OFS_W'(275);
         4'd1:    ofs = OFS_W'(306);
         4'd2:    ofs = OFS_W'(337);
         default: ofs = '0;
      endcase
      return ofs;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/date_interval_days_top.sv
// Top level of the day-interval block: absolute day count between two dates.
// Depends on did_pkg, did_ctrl and did_dpath.
//
//   channel   direction  handshake             payload
//   req_      in         req_valid/req_stall   two dates (year, month, day)
//   rsp_      out        rsp_valid/rsp_stall   day_count, invalid_date
//
// The controller walks both dates of each request through one shared datapath,
// four steps per date, then one step for the difference that writes the
// response register. No new request is taken until that last step is done.
// Reset is synchronous and active high; it empties the response register.
// A stalled result holds in the response register; a finished item waits in
// the final step only while that register is still full.
`default_nettype none

module date_interval_days_top
   import did_pkg::*;
(
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  wire  [YEAR_W-1:0]   req_first_year,
   input  wire  [MONTH_W-1:0]  req_first_month,
   input  wire  [DAY_W-1:0]    req_first_day,
   input  wire  [YEAR_W-1:0]   req_second_year,
   input  wire  [MONTH_W-1:0]  req_second_month,
   input  wire  [DAY_W-1:0]    req_second_day,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output logic [COUNT_W-1:0]  rsp_day_count,
   output logic                rsp_invalid_date
);

   cmd_type    cmd;
   status_type status;

   did_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd_o     (cmd),
      .status_i  (status)
   );

   did_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd_i            (cmd),
      .status_o         (status),
      .req_first_year   (req_first_year),
      .req_first_month  (req_first_month),
      .req_first_day    (req_first_day),
      .req_second_year  (req_second_year),
      .req_second_month (req_second_month),
      .req_second_day   (req_second_day),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_day_count    (rsp_day_count),
      .rsp_invalid_date (rsp_invalid_date)
   );

endmodule

`default_nettype wire

>>> rtl/core/did_ctrl.sv
// Sequencer for the day-interval block: walks both dates through the shared
// datapath steps. Depends on did_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module did_ctrl
   import did_pkg::*;
(
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_stall,
   output cmd_type    cmd_o,
   input  status_type status_i
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_DIV    = 6'b000010,
      ST_CHK    = 6'b000100,
      ST_MUL    = 6'b001000,
      ST_SUM    = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      sel_ff, sel_in;
   logic      accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      cmd_o    = '0;
      cmd_o.sel = sel_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_o.load = 1'b1;
               sel_in     = 1'b0;
               state_in   = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd_o.step_div = 1'b1;
            state_in       = ST_CHK;
         end
         ST_CHK: begin
            cmd_o.step_chk = 1'b1;
            state_in       = ST_MUL;
         end
         ST_MUL: begin
            cmd_o.step_mul = 1'b1;
            state_in       = ST_SUM;
         end
         ST_SUM: begin
            cmd_o.step_sum = 1'b1;
            if (sel_ff) begin
               state_in = ST_FINISH;
            end else begin
               sel_in   = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_FINISH: begin
            // hold until the response register can take the result
            if (!status_i.out_busy) begin
               cmd_o.finish = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sel_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
      end
   end

   `DID_ASSERT(a_accept_starts, clock, reset, accept |=> (state_ff == ST_DIV) && !sel_ff)
   `DID_ASSERT(a_second_pass_ends, clock, reset,
               (state_ff == ST_SUM && sel_ff) |=> (state_ff == ST_FINISH))
   `DID_ASSERT(a_finish_releases, clock, reset,
               (state_ff == ST_FINISH && !status_i.out_busy) |=> (state_ff == ST_IDLE))

endmodule

`default_nettype wire

>>> rtl/core/did_dpath.sv
// Datapath for the day-interval block: date checks, serial day numbers,
// difference and response register. Depends on did_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module did_dpath
   import did_pkg::*;
(
   input  wire                      clock,
   input  wire                      reset,
   input  cmd_type                  cmd_i,
   output status_type               status_o,
   input  wire  [YEAR_W-1:0]        req_first_year,
   input  wire  [MONTH_W-1:0]       req_first_month,
   input  wire  [DAY_W-1:0]         req_first_day,
   input  wire  [YEAR_W-1:0]        req_second_year,
   input  wire  [MONTH_W-1:0]       req_second_month,
   input  wire  [DAY_W-1:0]         req_second_day,
   output logic                     rsp_valid,
   input  wire                      rsp_stall,
   output logic [COUNT_W-1:0]       rsp_day_count,
   output logic                     rsp_invalid_date
);

   logic [YEAR_W-1:0]  year_a_ff, year_b_ff;
   logic [MONTH_W-1:0] month_a_ff, month_b_ff;
   logic [DAY_W-1:0]   day_a_ff, day_b_ff;

   logic [YEAR_W-1:0]  cur_y, yy_ff, div_op;
   logic [MONTH_W-1:0] cur_m;
   logic [DAY_W-1:0]   cur_d;

   logic [MUL_W-1:0]   prod100, prod400;
   logic [QUO_W-1:0]   qy100_ff, qy400_ff, q100_ff, q400_ff;
   logic [DN_W-1:0]    prod_ff, dn_a_ff, dn_b_ff, dn, diff;
   logic [REST_W-1:0]  rest_ff, rest_in;
   logic               bad_ff;
   logic               leap, year_ok, month_ok, day_ok;
   logic [DAY_W-1:0]   mlen;

   logic               rsp_valid_ff;
   logic [COUNT_W-1:0] rsp_count_ff, count_in;
   logic               rsp_bad_ff;

   assign cur_y = cmd_i.sel ? year_b_ff  : year_a_ff;
   assign cur_m = cmd_i.sel ? month_b_ff : month_a_ff;
   assign cur_d = cmd_i.sel ? day_b_ff   : day_a_ff;

   // one pair of reciprocal multipliers serves the year and the shifted year
   assign div_op  = cmd_i.step_chk ? yy_ff : cur_y;
   assign prod100 = MUL_W'(div_op) * MUL_W'(RECIP_100);
   assign prod400 = MUL_W'(div_op[YEAR_W-1:2]) * MUL_W'(RECIP_100);

   assign leap = ((cur_y[1:0] == 2'b00) &&
                  (CHK_W'(cur_y) != CHK_W'(qy100_ff) * CHK_W'(CENTURY))) ||
                 (CHK_W'(cur_y) == CHK_W'(qy400_ff) * CHK_W'(QUAD_CENTURY));
   assign mlen     = month_len(cur_m, leap);
   assign year_ok  = (cur_y != '0) && (cur_y <= YEAR_W'(MAX_YEAR));
   assign month_ok = (cur_m != '0) && (cur_m < MONTH_W'(MONTHS_END));
   assign day_ok   = (cur_d != '0) && (cur_d <= mlen);

   assign rest_in = REST_W'(yy_ff[YEAR_W-1:2]) - REST_W'(q100_ff) + REST_W'(q400_ff)
                  + REST_W'(march_offset(cur_m)) + REST_W'(cur_d) - REST_W'(1);

   assign dn   = prod_ff + DN_W'(rest_ff);
   assign diff = (dn_a_ff >= dn_b_ff) ? (dn_a_ff - dn_b_ff) : (dn_b_ff - dn_a_ff);

   always_comb begin
      if (bad_ff) begin
         count_in = '0;
      end else if (diff > DN_W'(COUNT_MAX)) begin
         count_in = COUNT_W'(COUNT_MAX);
      end else begin
         count_in = diff[COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_i.load) begin
         year_a_ff  <= req_first_year;
         month_a_ff <= req_first_month;
         day_a_ff   <= req_first_day;
         year_b_ff  <= req_second_year;
         month_b_ff <= req_second_month;
         day_b_ff   <= req_second_day;
      end
      if (cmd_i.step_div) begin
         // January and February count with the previous year
         yy_ff    <= (cur_m <= MONTH_W'(MONTH_FEB)) ? (cur_y - YEAR_W'(1)) : cur_y;
         qy100_ff <= prod100[RECIP_SHIFT +: QUO_W];
         qy400_ff <= prod400[RECIP_SHIFT +: QUO_W];
      end
      if (cmd_i.step_chk) begin
         q100_ff <= prod100[RECIP_SHIFT +: QUO_W];
         q400_ff <= prod400[RECIP_SHIFT +: QUO_W];
      end
      if (cmd_i.step_mul) begin
         prod_ff <= DN_W'(yy_ff) * DN_W'(DAYS_PER_YEAR);
         rest_ff <= rest_in;
      end
      if (cmd_i.step_sum) begin
         if (cmd_i.sel) begin
            dn_b_ff <= dn;
         end else begin
            dn_a_ff <= dn;
         end
      end
      if (cmd_i.finish) begin
         rsp_count_ff <= count_in;
         rsp_bad_ff   <= bad_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bad_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd_i.load) begin
            bad_ff <= 1'b0;
         end else if (cmd_i.step_chk) begin
            bad_ff <= bad_ff | !(year_ok && month_ok && day_ok);
         end
         if (cmd_i.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            // drop once the transfer completes
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status_o.out_busy = rsp_valid_ff && rsp_stall;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_day_count     = rsp_count_ff;
   assign rsp_invalid_date  = rsp_bad_ff;

   `DID_ASSERT(a_valid_from_finish, clock, reset, $rose(rsp_valid_ff) |-> $past(cmd_i.finish))
   `DID_ASSERT(a_invalid_zero, clock, reset,
               (rsp_valid_ff && rsp_bad_ff) |-> (rsp_count_ff == '0))
   `DID_ASSERT(a_no_overwrite, clock, reset, cmd_i.finish |-> !status_o.out_busy)

endmodule

`default_nettype wire
